// ----- design/lbpc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LED blink and pulse controller package
// Shared widths, reset values and command codes.
// ----------------------------------------------------------------------------
package lbpc_pkg;

    localparam int PATTERN_W      = 50;
    localparam int PATTERN_LENGTH = 50;
    localparam int STEP_W         = $clog2(PATTERN_LENGTH);
    localparam int PULSE_BITS     = 16;
    localparam int NUM_LEDS       = 4;
    localparam int LEVEL_W        = 4;
    localparam int PRESCALE_W     = 4;
    localparam int CFG_INDEX_W    = 2;

    localparam logic [PATTERN_W-1:0]  PATTERN_RESET  = 50'h300C0300C0300;
    localparam logic [PRESCALE_W-1:0] PRESCALE_RESET = 4'd10;
    localparam logic [LEVEL_W-1:0]    LEVEL_FULL     = 4'hF;

    typedef enum logic [1:0] {
        CMD_TICK  = 2'd0,
        CMD_LEVEL = 2'd1,
        CMD_PULSE = 2'd2,
        CMD_ERROR = 2'd3
    } cmd_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_PATTERN  = 2'd0,
        CFG_PRESCALE = 2'd1,
        CFG_SPARE2   = 2'd2,
        CFG_SPARE3   = 2'd3
    } cfg_reg_t;

    typedef logic [PULSE_BITS-1:0] pulse_cnt_t;

endpackage

// ----- design/led_blink_pulse_controller_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LED blink and pulse controller
// Drives four LEDs from tick, set level, pulse and error commands.
// ----------------------------------------------------------------------------
// An accepted beat's result appears on led_drive in the cycle after it is accepted.
// Throughput: one beat per cycle while out_ready is high; the state update is a single pass of
// counter and bit logic into the state registers, which also hold the result.
// Reset: mode, counters, level and shown value clear; the pattern and
// prescale registers take their defaults. No clearing pass is needed.
module led_blink_pulse_controller_core (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [1:0]                      command,
    input  logic [7:0]                      level_value,
    input  logic [1:0]                      led_index,
    input  logic [15:0]                     pulse_ticks,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [3:0]                      led_drive,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [lbpc_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [lbpc_pkg::PATTERN_W-1:0]   cfg_data
);
    import lbpc_pkg::*;

    logic [PATTERN_W-1:0]  pattern_reg;
    logic [PRESCALE_W-1:0] prescale_reg;
    logic [LEVEL_W-1:0]    level_reg, level_next;
    logic [LEVEL_W-1:0]    shown_reg, shown_next;
    logic [PRESCALE_W-1:0] count_reg, count_next;
    logic [STEP_W-1:0]     step_reg, step_next;
    logic                  blink_reg, blink_next;
    logic                  pulse_reg, pulse_next;
    pulse_cnt_t            left_reg  [NUM_LEDS];
    pulse_cnt_t            left_next [NUM_LEDS];
    logic                  out_valid_reg;

    logic                  in_fire;
    logic [PRESCALE_W:0]   count_inc;
    logic                  pattern_bit;
    cmd_t                  cmd;

    assign in_fire   = in_valid && in_ready;
    assign in_ready  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign led_drive = shown_reg;
    assign cfg_ready = 1'b1;
    assign cmd       = cmd_t'(command);

    assign count_inc   = {1'b0, count_reg} + {{PRESCALE_W{1'b0}}, 1'b1};
    // Steps beyond the register width read as zero.
    assign pattern_bit = (32'(step_reg) < 32'(PATTERN_W)) ? pattern_reg[step_reg] : 1'b0;

    always_comb
    begin
        level_next = level_reg;
        shown_next = shown_reg;
        count_next = count_reg;
        step_next  = step_reg;
        blink_next = blink_reg;
        pulse_next = pulse_reg;
        for (int i = 0; i < NUM_LEDS; i++)
        begin
            left_next[i] = left_reg[i];
        end

        case (cmd)
            CMD_TICK:
            begin
                if (blink_reg)
                begin
                    count_next = count_inc[PRESCALE_W-1:0];
                    if (count_inc >= {1'b0, prescale_reg})
                    begin
                        count_next = '0;
                        if (level_reg == '0)
                        begin
                            shown_next = (step_reg == '0) ? LEVEL_FULL : '0;
                        end
                        else
                        begin
                            shown_next = pattern_bit ? level_reg : '0;
                        end
                        if (32'(step_reg) + 1 >= PATTERN_LENGTH)
                        begin
                            step_next = '0;
                        end
                        else
                        begin
                            step_next = step_reg + STEP_W'(1);
                        end
                    end
                end
                else
                begin
                    if (pulse_reg)
                    begin
                        for (int i = 0; i < NUM_LEDS; i++)
                        begin
                            if (left_reg[i] != '0)
                            begin
                                left_next[i]  = left_reg[i] - pulse_cnt_t'(1);
                                level_next[i] = 1'b1;
                            end
                            else
                            begin
                                level_next[i] = 1'b0;
                            end
                        end
                    end
                    shown_next = level_next;
                end
            end
            CMD_LEVEL:
            begin
                if (level_value[7:LEVEL_W] == '0)
                begin
                    level_next = level_value[LEVEL_W-1:0];
                end
            end
            CMD_PULSE:
            begin
                left_next[led_index] = pulse_ticks[PULSE_BITS-1:0];
                pulse_next = 1'b1;
                blink_next = 1'b0;
            end
            CMD_ERROR:
            begin
                blink_next = 1'b1;
                level_next = LEVEL_FULL;
            end
            default:
            begin
                level_next = level_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_reg   <= PATTERN_RESET;
            prescale_reg  <= PRESCALE_RESET;
            level_reg     <= '0;
            shown_reg     <= '0;
            count_reg     <= '0;
            step_reg      <= '0;
            blink_reg     <= 1'b0;
            pulse_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_LEDS; i++)
            begin
                left_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_reg_t'(cfg_index))
                    CFG_PATTERN:  pattern_reg  <= cfg_data;
                    CFG_PRESCALE: prescale_reg <= cfg_data[PRESCALE_W-1:0];
                    default:      pattern_reg  <= pattern_reg;
                endcase
            end
            if (in_fire)
            begin
                level_reg     <= level_next;
                shown_reg     <= shown_next;
                count_reg     <= count_next;
                step_reg      <= step_next;
                blink_reg     <= blink_next;
                pulse_reg     <= pulse_next;
                out_valid_reg <= 1'b1;
                for (int i = 0; i < NUM_LEDS; i++)
                begin
                    left_reg[i] <= left_next[i];
                end
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

// ----- design/lbpc_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LED blink and pulse controller checker
// Port-level assertions on the result register and its handshake.
// ----------------------------------------------------------------------------
module lbpc_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [3:0] led_drive
);

    // Every accepted beat yields a result in the next cycle.
    a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> out_valid)
        else $error("accepted beat produced no result");

    // With no result pending the block must take input.
    a_empty_is_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty result register");

    // A taken result with no new beat leaves the output empty.
    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !(in_valid && in_ready) |=> !out_valid)
        else $error("result repeated without a new beat");

    // A stalled result holds its value.
    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(led_drive))
        else $error("stalled result changed");

endmodule

bind led_blink_pulse_controller_core lbpc_checker u_lbpc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .led_drive (led_drive)
);
